[hdl/dtq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg - shared types and codes for the deadline timer queue
// Request and result transfer formats, request functions and result kinds.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam logic [1:0] FUNC_SCHEDULE   = 2'd0;
  localparam logic [1:0] FUNC_UNSCHEDULE = 2'd1;
  localparam logic [1:0] FUNC_UPDATE     = 2'd2;
  localparam logic [1:0] FUNC_RESET_ALL  = 2'd3;

  localparam logic [1:0] KIND_FIRED    = 2'd0;
  localparam logic [1:0] KIND_WAIT     = 2'd1;
  localparam logic [1:0] KIND_ACCEPTED = 2'd2;
  localparam logic [1:0] KIND_IGNORED  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  task_id;
    logic [63:0] time_value;
    logic [63:0] idle_wait;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fired_id;
    logic [63:0] wait_ticks;
    logic        last;
  } out_t;

endpackage
`default_nettype wire

[hdl/deadline_timer_queue_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_queue_core - deadline timer over a fixed set of task slots
// Schedule / unschedule / update / reset-all requests; update fires expired
// slots in deadline order (lower slot on ties) and then reports next wait.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  request | in_valid, in_stall, in_data    | in
//  result  | out_valid, out_stall, out_data | out
//
// Schedule, unschedule and reset-all each give one result.
// An update makes one scan of the deadline RAM per result, reading one entry a
// cycle, then decides once the last read has been compared; the decision
// waits while the result side stalls.
// Armed bits live in flops cleared by reset; deadlines need no clearing.
// A request is taken while a result waits only if that result leaves too.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core #(
  parameter int TASK_SLOTS = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  dtq_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output dtq_pkg::out_t  out_data
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int CW = SW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [SW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  found_r, found_nxt;
  logic [SW-1:0]         best_idx_r, best_idx_nxt;
  logic [63:0]           best_dl_r, best_dl_nxt;
  logic [63:0]           now_r, now_nxt;
  logic [63:0]           idle_r, idle_nxt;
  logic [TASK_SLOTS-1:0] armed_r, armed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dtq_pkg::out_t         out_data_r, out_data_nxt;

  // deadline RAM
  logic [63:0]   dl_mem [TASK_SLOTS];
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          mem_re;
  logic [SW-1:0] mem_raddr;
  logic [63:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= dl_mem[mem_raddr];
    end
  end

  logic          in_xfer;
  logic          out_free;
  logic [31:0]   id_wide;
  logic          id_ok;
  logic [SW+3:0] id_ext;
  logic [SW-1:0] id_idx;
  logic          id_armed;
  logic [SW+3:0] fid_ext;
  logic          expired;
  logic [63:0]   wait_calc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign id_wide   = {28'd0, in_data.task_id};
  assign id_ok     = id_wide < 32'(TASK_SLOTS);
  assign id_ext    = {{SW{1'b0}}, in_data.task_id};
  assign id_idx    = id_ext[SW-1:0];
  assign id_armed  = id_ok && armed_r[id_idx];
  assign fid_ext   = {4'd0, best_idx_r};
  assign expired   = found_r && (best_dl_r <= now_r);
  assign wait_calc = found_r ? (best_dl_r - now_r) : idle_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_dl_nxt   = best_dl_r;
    now_nxt       = now_r;
    idle_nxt      = idle_r;
    armed_nxt     = armed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = id_idx;
    mem_wdata     = in_data.time_value;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[SW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          out_data_nxt.fired_id   = in_data.task_id;
          out_data_nxt.wait_ticks = 64'd0;
          out_data_nxt.last       = 1'b1;
          case (in_data.func)
            dtq_pkg::FUNC_SCHEDULE: begin
              out_valid_nxt = 1'b1;
              if (id_ok && !id_armed) begin
                armed_nxt[id_idx] = 1'b1;
                mem_we            = 1'b1;
                out_data_nxt.kind = dtq_pkg::KIND_ACCEPTED;
              end else begin
                out_data_nxt.kind = dtq_pkg::KIND_IGNORED;
              end
            end
            dtq_pkg::FUNC_UNSCHEDULE: begin
              out_valid_nxt = 1'b1;
              if (id_armed) begin
                armed_nxt[id_idx] = 1'b0;
                out_data_nxt.kind = dtq_pkg::KIND_ACCEPTED;
              end else begin
                out_data_nxt.kind = dtq_pkg::KIND_IGNORED;
              end
            end
            dtq_pkg::FUNC_RESET_ALL: begin
              out_valid_nxt         = 1'b1;
              armed_nxt             = '0;
              out_data_nxt.kind     = dtq_pkg::KIND_ACCEPTED;
              out_data_nxt.fired_id = 4'd0;
            end
            default: begin
              now_nxt   = in_data.time_value;
              idle_nxt  = in_data.idle_wait;
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read one slot per cycle, compare the previous read
        if (cnt_r != CW'(TASK_SLOTS)) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = cnt_r[SW-1:0];
          cnt_nxt     = cnt_r + CW'(1);
        end else if (!rd_pend_r) begin
          state_nxt = ST_DECIDE;
        end
        if (rd_pend_r && armed_r[rd_idx_r] && (!found_r || rd_data_r < best_dl_r)) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_dl_nxt  = rd_data_r;
        end
      end

      ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (expired) begin
            armed_nxt[best_idx_r]   = 1'b0;
            out_data_nxt.kind       = dtq_pkg::KIND_FIRED;
            out_data_nxt.fired_id   = fid_ext[3:0];
            out_data_nxt.wait_ticks = 64'd0;
            out_data_nxt.last       = 1'b0;
            cnt_nxt                 = '0;
            found_nxt               = 1'b0;
            state_nxt               = ST_SCAN;
          end else begin
            out_data_nxt.kind       = dtq_pkg::KIND_WAIT;
            out_data_nxt.fired_id   = 4'd0;
            out_data_nxt.wait_ticks = wait_calc;
            out_data_nxt.last       = 1'b1;
            state_nxt               = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    now_r      <= now_nxt;
    idle_r     <= idle_nxt;
    out_data_r <= out_data_nxt;
  end

  // fired results are never the final one of an update
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind == dtq_pkg::KIND_FIRED |-> !out_data_r.last)
    else $error("fired transfer marked last");

  // wait result always closes an update
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind == dtq_pkg::KIND_WAIT |-> out_data_r.last)
    else $error("wait transfer not marked last");

  // an accepted update starts a scan
  a_update_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.func == dtq_pkg::FUNC_UPDATE |=> state_r == ST_SCAN)
    else $error("update did not start scan");

  // the chosen slot is still armed when the decision is made
  a_best_armed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DECIDE && found_r |-> armed_r[best_idx_r])
    else $error("best slot not armed");

endmodule
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for deadline_timer_queue_core
// Drives schedule, unschedule, update and reset-all requests and keeps its
// own copy of the slot table to predict every result. A monitor checks each
// result transfer in order. Sender gaps and receiver stalls vary by phase,
// and one phase holds off the receiver long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS           = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int RANDOM_ITEMS    = 120;
  localparam logic [63:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dtq_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dtq_pkg::out_t out_data;

  // timer table as the bench sees it
  logic          slot_armed [SLOTS];
  logic [63:0]   slot_deadline [SLOTS];
  dtq_pkg::out_t timer_results_due [$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_pending = 1'b0;
  logic [63:0] timeline_now = '0;

  int mismatch_count = 0;
  int results_checked = 0;
  int fires_seen = 0;
  int ignored_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  deadline_timer_queue_core #(
    .TASK_SLOTS(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_checked, msg);
    mismatch_count++;
  endtask

  // Expected results for one accepted request; updates the bench's table.
  task automatic predict_timer_results(input dtq_pkg::in_t req);
    dtq_pkg::out_t res;
    int best;
    int s;
    bit done;
    res = '0;
    res.last = 1'b1;
    case (req.func)
      dtq_pkg::FUNC_SCHEDULE: begin
        res.fired_id = req.task_id;
        if (!slot_armed[req.task_id]) begin
          slot_armed[req.task_id] = 1'b1;
          slot_deadline[req.task_id] = req.time_value;
          res.kind = dtq_pkg::KIND_ACCEPTED;
        end else begin
          res.kind = dtq_pkg::KIND_IGNORED;
        end
        timer_results_due.push_back(res);
      end
      dtq_pkg::FUNC_UNSCHEDULE: begin
        res.fired_id = req.task_id;
        if (slot_armed[req.task_id]) begin
          slot_armed[req.task_id] = 1'b0;
          res.kind = dtq_pkg::KIND_ACCEPTED;
        end else begin
          res.kind = dtq_pkg::KIND_IGNORED;
        end
        timer_results_due.push_back(res);
      end
      dtq_pkg::FUNC_RESET_ALL: begin
        for (s = 0; s < SLOTS; s++) slot_armed[s] = 1'b0;
        res.kind = dtq_pkg::KIND_ACCEPTED;
        timer_results_due.push_back(res);
      end
      default: begin
        done = 1'b0;
        while (!done) begin
          best = -1;
          for (s = 0; s < SLOTS; s++) begin
            if (slot_armed[s] && (best < 0 || slot_deadline[s] < slot_deadline[best]))
              best = s;
          end
          res = '0;
          if (best < 0) begin
            res.kind = dtq_pkg::KIND_WAIT;
            res.wait_ticks = req.idle_wait;
            res.last = 1'b1;
            done = 1'b1;
          end else if (slot_deadline[best] > req.time_value) begin
            res.kind = dtq_pkg::KIND_WAIT;
            res.wait_ticks = slot_deadline[best] - req.time_value;
            res.last = 1'b1;
            done = 1'b1;
          end else begin
            slot_armed[best] = 1'b0;
            res.kind = dtq_pkg::KIND_FIRED;
            res.fired_id = best[3:0];
          end
          timer_results_due.push_back(res);
        end
      end
    endcase
  endtask

  task automatic check_timer_result(input dtq_pkg::out_t got);
    dtq_pkg::out_t want;
    if (timer_results_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind %0d id %0d", got.kind, got.fired_id));
    end else begin
      want = timer_results_due.pop_front();
      if (got.kind !== want.kind)
        flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.fired_id !== want.fired_id)
        flag_mismatch($sformatf("fired_id %0d, expected %0d", got.fired_id, want.fired_id));
      if (got.wait_ticks !== want.wait_ticks)
        flag_mismatch($sformatf("wait_ticks %0h, expected %0h", got.wait_ticks,
                                want.wait_ticks));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      if (want.kind == dtq_pkg::KIND_FIRED) fires_seen++;
      if (want.kind == dtq_pkg::KIND_IGNORED) ignored_seen++;
    end
    results_checked++;
  endtask

  // Request side first, so a same-edge result always finds its prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_timer_results(in_data);
      if (out_valid && !out_stall) check_timer_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results still due",
               idle_cycles, timer_results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result receiver: random stalls, or one long hold-off on request.
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        for (held = 1; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Valid stays up between back-to-back transfers; it only drops for a gap.
  task automatic send_request(input logic [1:0] func, input logic [3:0] slot,
                              input logic [63:0] tval, input logic [63:0] idle);
    dtq_pkg::in_t req;
    req.func = func;
    req.task_id = slot;
    req.time_value = tval;
    req.idle_wait = idle;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drops valid so the last request is not taken again, then waits out results.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (timer_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_requests();
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, 64'd0, 64'd0);
    send_request(dtq_pkg::FUNC_UPDATE, 4'd9, TIME_MAX, TIME_MAX);
    send_request(dtq_pkg::FUNC_UNSCHEDULE, 4'd0, 64'd0, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd0, 64'd0, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd0, 64'd5, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd15, TIME_MAX, TIME_MAX);
    send_request(dtq_pkg::FUNC_UNSCHEDULE, 4'd15, rand64(), rand64());
    send_request(dtq_pkg::FUNC_UNSCHEDULE, 4'd15, 64'd0, 64'd0);
    // stray fields on reset-all must not leak into the result
    send_request(dtq_pkg::FUNC_RESET_ALL, 4'd15, TIME_MAX, TIME_MAX);
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, 64'd0, 64'd123);
  endtask

  task automatic test_update_ordering();
    // equal deadlines scheduled high slot first: firing must still go low first
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd7, 64'd100, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd2, 64'd100, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd9, 64'd40, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd0, 64'd0, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd15, TIME_MAX, 64'd0);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd4, 64'd101, 64'd0);
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, 64'd99, rand64());
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, 64'd100, rand64());
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, TIME_MAX, 64'h8000_0000_0000_0001);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd3, 64'd200, 64'd0);
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, 64'd200, 64'd77);
    send_request(dtq_pkg::FUNC_SCHEDULE, 4'd5, TIME_MAX, 64'd0);
    send_request(dtq_pkg::FUNC_RESET_ALL, 4'd0, 64'd0, 64'd0);
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, 64'd0, 64'd1);
  endtask

  // Every slot armed, then one update that fires them all.
  task automatic test_full_queue();
    int s;
    send_request(dtq_pkg::FUNC_RESET_ALL, 4'd0, 64'd0, 64'd0);
    for (s = 0; s < SLOTS; s++)
      send_request(dtq_pkg::FUNC_SCHEDULE, s[3:0],
                   ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(3) * 10), 64'd0);
    send_request(dtq_pkg::FUNC_UPDATE, 4'd0, TIME_MAX, rand64());
  endtask

  task automatic test_receiver_hold_off();
    int n;
    hold_off_pending = 1'b1;
    send_request(dtq_pkg::FUNC_RESET_ALL, 4'd0, 64'd0, 64'd0);
    for (n = 0; n < 24; n++) begin
      if (n % 6 == 5)
        send_request(dtq_pkg::FUNC_UPDATE, 4'd0, 64'($urandom_range(400)), rand64());
      else
        send_request(dtq_pkg::FUNC_SCHEDULE, 4'($urandom_range(15)),
                     64'($urandom_range(400)), 64'd0);
    end
  endtask

  // Prefer a slot in the wanted state so most calls are accepted.
  function automatic logic [3:0] pick_slot(input bit want_armed);
    logic [3:0] slot;
    int tries;
    slot = 4'($urandom_range(15));
    for (tries = 0; tries < 16 && slot_armed[slot] != want_armed; tries++)
      slot = 4'($urandom_range(15));
    return slot;
  endfunction

  task automatic test_random_traffic(input int count);
    int n;
    int pick;
    logic [3:0] slot;
    logic [63:0] tval;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      tval = rand64();
      if (pick < 45) begin
        slot = ($urandom_range(9) < 8) ? pick_slot(1'b0) : 4'($urandom_range(15));
        if ($urandom_range(9) != 0) tval = timeline_now + 64'($urandom_range(300));
        send_request(dtq_pkg::FUNC_SCHEDULE, slot, tval, rand64());
      end else if (pick < 65) begin
        slot = ($urandom_range(9) < 7) ? pick_slot(1'b1) : 4'($urandom_range(15));
        send_request(dtq_pkg::FUNC_UNSCHEDULE, slot, tval, rand64());
      end else if (pick < 95) begin
        // mostly a clock moving forward, now and then a jump near the top
        if ($urandom_range(49) == 0)
          timeline_now = TIME_MAX - 64'($urandom_range(500));
        else
          timeline_now = timeline_now + 64'($urandom_range(150));
        tval = ($urandom_range(19) == 0) ? rand64() : timeline_now;
        send_request(dtq_pkg::FUNC_UPDATE, 4'($urandom_range(15)), tval, rand64());
      end else begin
        send_request(dtq_pkg::FUNC_RESET_ALL, 4'($urandom_range(15)), tval, rand64());
      end
    end
  endtask

  initial begin
    int s;
    for (s = 0; s < SLOTS; s++) begin
      slot_armed[s] = 1'b0;
      slot_deadline[s] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 22;
    recv_stall_pct = 85;
    test_basic_requests();
    test_update_ordering();
    test_full_queue();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();

    sender_idle_pct = 85;
    recv_stall_pct = 22;
    test_full_queue();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();

    sender_idle_pct = 0;
    recv_stall_pct = 0;
    test_receiver_hold_off();
    test_random_traffic(RANDOM_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over three gap/stall mixes plus a long receiver hold-off;",
             items_sent);
    $display("checked %0d results: %0d slot firings, %0d ignored calls, %0d mismatches.",
             results_checked, fires_seen, ignored_seen, mismatch_count);
    if (mismatch_count == 0 && timer_results_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
